/* hdl/bsil_pkg.sv */
// Shared constants and types for the bounded sorted insert list.
// No dependencies; used by bsil_ram users and the core top level.
package bsil_pkg;

  // List depth and the widths that follow from it
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ENT_W    = 10;
  localparam int unsigned PAY_W    = 64;
  localparam int unsigned RIDX_W   = 6;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned OCNT_W   = 7;

  // Width for comparing a read index against the count
  localparam int unsigned RCMP_W   = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_BEYOND   = 2'd3;

  // One stored list entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ENT_W-1:0] ent;
    logic [PAY_W-1:0] pay;
  } entry_t;

endpackage

/* hdl/bsil_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bsil_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bounded_sorted_insert_list_core.sv */
// Bounded sorted insert list core: up to CAPACITY entries kept in ascending key order.
// Steps: read and clear pass S_RESP into the output register; insert runs search probes,
//   up to 7 (S_SRCH/S_CMP), one S_SHIFT per kept entry above the slot, S_PUT and S_RESP.
// Throughput: one beat at a time; a new beat is taken once the last one left the sequencer.
// Reset: rst_ni low clears the count and the handshake state; RAM contents are not cleared.
// Depends on bsil_pkg and bsil_ram.
module bounded_sorted_insert_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsil_pkg::OP_W-1:0]     op_i,
  input  logic [bsil_pkg::KEY_W-1:0]    dist_key_i,
  input  logic [bsil_pkg::ENT_W-1:0]    entity_id_i,
  input  logic [bsil_pkg::PAY_W-1:0]    payload_i,
  input  logic [bsil_pkg::RIDX_W-1:0]   read_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsil_pkg::STAT_W-1:0]   status_o,
  output logic [bsil_pkg::POS_W-1:0]    position_o,
  output logic [bsil_pkg::OCNT_W-1:0]   entry_count_o,
  output logic [bsil_pkg::KEY_W-1:0]    key_out_o,
  output logic [bsil_pkg::ENT_W-1:0]    entity_out_o,
  output logic [bsil_pkg::PAY_W-1:0]    payload_out_o
);

  localparam int unsigned CNT_W = bsil_pkg::CNT_W;
  localparam int unsigned IDX_W = bsil_pkg::IDX_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a beat
  localparam logic [2:0] S_SRCH  = 3'd1;  // binary search: issue probe or finish
  localparam logic [2:0] S_CMP   = 3'd2;  // binary search: compare probe data
  localparam logic [2:0] S_SHIFT = 3'd3;  // move one entry up per cycle
  localparam logic [2:0] S_PUT   = 3'd4;  // store the new entry
  localparam logic [2:0] S_RESP  = 3'd5;  // hand the result to the output register

  logic [2:0]                   state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             lo_q, lo_d;      // search lower bound, later insert position
  logic [CNT_W-1:0]             hi_q, hi_d;
  logic [CNT_W-1:0]             mid_q, mid_d;
  logic [CNT_W-1:0]             top_q, top_d;    // entries kept before the insert
  logic [IDX_W-1:0]             sidx_q, sidx_d;  // next shift write address
  logic [bsil_pkg::STAT_W-1:0]  stat_q, stat_d;
  logic [bsil_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                         rdhit_q, rdhit_d; // result carries entry data
  bsil_pkg::entry_t             new_q, new_d;

  // Output register
  logic                         out_valid_q;
  logic [bsil_pkg::STAT_W-1:0]  out_stat_q;
  logic [bsil_pkg::POS_W-1:0]   out_pos_q;
  logic [bsil_pkg::OCNT_W-1:0]  out_cnt_q;
  bsil_pkg::entry_t             out_ent_q;

  // RAM ports
  logic                         ram_we, ram_re;
  logic [IDX_W-1:0]             ram_waddr, ram_raddr;
  bsil_pkg::entry_t             ram_wdata, ram_rdata;

  logic                         in_acc;
  logic                         out_free;
  logic [CNT_W:0]               mid_sum;
  logic [CNT_W-1:0]             mid_w;
  logic                         full_w;
  logic [CNT_W-1:0]             keep_w;
  logic [bsil_pkg::RCMP_W-1:0]  ridx_ext, cnt_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // midpoint of the search window, one guard bit against overflow
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = mid_sum[CNT_W:1];

  // a full list drops its last entry before shifting
  assign full_w = (count_q == CNT_W'(bsil_pkg::CAPACITY));
  assign keep_w = full_w ? CNT_W'(bsil_pkg::CAPACITY - 1) : count_q;

  assign ridx_ext = bsil_pkg::RCMP_W'(read_index_i);
  assign cnt_ext  = bsil_pkg::RCMP_W'(count_q);

  bsil_ram #(
    .WIDTH ($bits(bsil_pkg::entry_t)),
    .DEPTH (bsil_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    top_d     = top_q;
    sidx_d    = sidx_q;
    stat_d    = stat_q;
    pos_d     = pos_q;
    rdhit_d   = rdhit_q;
    new_d     = new_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = sidx_q;
    ram_wdata = ram_rdata;
    ram_raddr = mid_w[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          new_d.key = dist_key_i;
          new_d.ent = entity_id_i;
          new_d.pay = payload_i;
          stat_d    = bsil_pkg::ST_DONE;
          pos_d     = '0;
          rdhit_d   = 1'b0;
          state_d   = S_RESP;
          case (op_i)
            bsil_pkg::OP_INSERT: begin
              lo_d    = '0;
              hi_d    = count_q;
              state_d = S_SRCH;
            end
            bsil_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            bsil_pkg::OP_READ: begin
              pos_d = bsil_pkg::POS_W'(read_index_i);
              if (ridx_ext < cnt_ext) begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(read_index_i);
                rdhit_d   = 1'b1;
              end else begin
                stat_d = bsil_pkg::ST_BEYOND;
              end
            end
            default: begin
              // unused code: plain done result
            end
          endcase
        end
      end

      S_SRCH: begin
        if (lo_q < hi_q) begin
          ram_re    = 1'b1;
          ram_raddr = mid_w[IDX_W-1:0];
          mid_d     = mid_w;
          state_d   = S_CMP;
        end else begin
          pos_d = bsil_pkg::POS_W'(lo_q);
          if (lo_q == CNT_W'(bsil_pkg::CAPACITY)) begin
            stat_d  = bsil_pkg::ST_REJECTED;
            state_d = S_RESP;
          end else begin
            if (full_w) begin
              stat_d = bsil_pkg::ST_DROPPED;
            end
            top_d = keep_w;
            if (keep_w > lo_q) begin
              // prime the shift walk with the last kept entry
              ram_re    = 1'b1;
              ram_raddr = IDX_W'(keep_w - CNT_W'(1));
              sidx_d    = IDX_W'(keep_w);
              state_d   = S_SHIFT;
            end else begin
              state_d = S_PUT;
            end
          end
        end
      end

      S_CMP: begin
        // equal keys go after existing ones
        if (new_q.key >= ram_rdata.key) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = sidx_q;
        ram_wdata = ram_rdata;
        if (CNT_W'(sidx_q) > lo_q + CNT_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = sidx_q - IDX_W'(2);
          sidx_d    = sidx_q - IDX_W'(1);
        end else begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[IDX_W-1:0];
        ram_wdata = new_q;
        count_d   = top_q + CNT_W'(1);
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    top_q   <= top_d;
    sidx_q  <= sidx_d;
    stat_q  <= stat_d;
    pos_q   <= pos_d;
    rdhit_q <= rdhit_d;
    new_q   <= new_d;
    if ((state_q == S_RESP) && out_free) begin
      out_stat_q <= stat_q;
      out_pos_q  <= pos_q;
      out_cnt_q  <= bsil_pkg::OCNT_W'(count_q);
      out_ent_q  <= rdhit_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign position_o    = out_pos_q;
  assign entry_count_o = out_cnt_q;
  assign key_out_o     = out_ent_q.key;
  assign entity_out_o  = out_ent_q.ent;
  assign payload_out_o = out_ent_q.pay;

  // The list never grows past its capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(bsil_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // Search window stays ordered and probes lie inside it
  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (lo_q <= mid_q && mid_q < hi_q))
    else $error("search probe outside window");

  // Shift writes only land above the insert position and at or below the kept count
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CNT_W'(sidx_q) > lo_q && CNT_W'(sidx_q) <= top_q))
    else $error("shift write outside range");

  // A clear empties the list at once
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i == bsil_pkg::OP_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty list");

  // A rejected insert only happens on a full list, whose count it leaves unchanged
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && stat_q == bsil_pkg::ST_REJECTED) |->
      (count_q == CNT_W'(bsil_pkg::CAPACITY)))
    else $error("reject on a list that is not full");

endmodule
